FILE: sv/signed_integer_alu_top_assert.svh
// Assertion macros for the signed integer ALU.
`ifndef SIGNED_INTEGER_ALU_TOP_ASSERT_SVH
`define SIGNED_INTEGER_ALU_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SIA_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SIA_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SIA_ASSERT_IMP(label, clk_s, rst_s, ante, cons)
`define SIA_ASSERT_NXT(label, clk_s, rst_s, ante, cons)
`endif
`endif

FILE: sv/sia_pkg.sv
// Shared types and constants for the signed integer ALU.
`default_nettype none
package sia_pkg;
  localparam int DataWidth = 64;
  localparam int ModeWidth = 5;
  localparam int DivSteps  = 16;

  localparam logic [ModeWidth-1:0] OP_MUL  = 5'd0;
  localparam logic [ModeWidth-1:0] OP_DIV  = 5'd1;
  localparam logic [ModeWidth-1:0] OP_ADD  = 5'd2;
  localparam logic [ModeWidth-1:0] OP_SUB  = 5'd3;
  localparam logic [ModeWidth-1:0] OP_SHL  = 5'd4;
  localparam logic [ModeWidth-1:0] OP_SHR  = 5'd5;
  localparam logic [ModeWidth-1:0] OP_EQ   = 5'd6;
  localparam logic [ModeWidth-1:0] OP_NE   = 5'd7;
  localparam logic [ModeWidth-1:0] OP_LT   = 5'd8;
  localparam logic [ModeWidth-1:0] OP_GT   = 5'd9;
  localparam logic [ModeWidth-1:0] OP_LE   = 5'd10;
  localparam logic [ModeWidth-1:0] OP_GE   = 5'd11;
  localparam logic [ModeWidth-1:0] OP_AND  = 5'd12;
  localparam logic [ModeWidth-1:0] OP_NAND = 5'd13;
  localparam logic [ModeWidth-1:0] OP_OR   = 5'd14;
  localparam logic [ModeWidth-1:0] OP_NOR  = 5'd15;
  localparam logic [ModeWidth-1:0] OP_XOR  = 5'd16;
  localparam logic [ModeWidth-1:0] OP_XNOR = 5'd17;
  localparam logic [ModeWidth-1:0] OP_NEG  = 5'd18;
  localparam logic [ModeWidth-1:0] OP_NOT  = 5'd19;

  typedef logic [DataWidth-1:0] word_t;
endpackage
`default_nettype wire

FILE: sv/signed_integer_alu_top.sv
// Top level of the pipelined 64-bit signed integer ALU.
// Usage:
//   Input channel: in_valid/in_ready carry in_operand_a, in_operand_b, in_mode.
//   Result channel: out_valid/out_ready carry out_result, out_divide_error.
//   Each accepted word gives exactly one result word, in order.
// Pipeline depth: set by the sixteen-stage divider plus its sign-fix register;
//   all other operations are delayed to match.
// Throughput: one word per cycle while the result channel is not stalled; every operation runs the same pipeline.
// Stall: the whole pipeline advances only when its last stage is empty or
//   taken, so a stalled receiver holds every stage and in_ready drops;
//   nothing is lost or repeated.
// Reset: rst_n (synchronous, active low) clears all stage valid bits.
// Multiply is split into 32x32 partial products in stage one and summed
//   in stage two.
`default_nettype none
`include "signed_integer_alu_top_assert.svh"
module signed_integer_alu_top import sia_pkg::*; #(
  parameter int Steps = DivSteps
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [63:0]   in_operand_a,
  input  wire logic signed [63:0]   in_operand_b,
  input  wire logic [4:0]           in_mode,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [63:0]        out_result,
  output logic                      out_divide_error
);
  localparam int Depth = Steps + 1;

  logic adv;
  logic [Depth-1:0] v_r;
  assign adv      = !v_r[Depth-1] || out_ready;
  assign in_ready = adv;

  // valid pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[Depth-2:0], in_valid};
    end
  end

  // stage 1: simple ops, partial products, divider operands
  word_t a, b, simp_nxt, simp_r, mag_a, mag_b;
  logic lt, eq;
  logic [63:0] pll_r;
  logic [31:0] plh_r, phl_r;
  logic [4:0] mode_r;
  logic negq_r, dz_r, dz_nxt;
  word_t a1_r;
  assign a = in_operand_a;
  assign b = in_operand_b;
  assign eq = (a == b);
  assign lt = ($signed(a) < $signed(b));
  assign mag_a = a[63] ? (word_t'(0) - a) : a;
  assign mag_b = b[63] ? (word_t'(0) - b) : b;
  assign dz_nxt = (b == '0);

  always_comb begin
    case (in_mode)
      OP_ADD:  simp_nxt = a + b;
      OP_SUB:  simp_nxt = a - b;
      OP_SHL:  simp_nxt = (b[63:6] != '0) ? '0 : (a << b[5:0]);
      OP_SHR:  simp_nxt = word_t'($signed(a) >>> ((b[63:6] != '0) ? 6'd63 : b[5:0]));
      OP_EQ:   simp_nxt = {64{eq}};
      OP_NE:   simp_nxt = {64{!eq}};
      OP_LT:   simp_nxt = {64{lt}};
      OP_GT:   simp_nxt = {64{!lt && !eq}};
      OP_LE:   simp_nxt = {64{lt || eq}};
      OP_GE:   simp_nxt = {64{!lt}};
      OP_AND:  simp_nxt = a & b;
      OP_NAND: simp_nxt = ~(a & b);
      OP_OR:   simp_nxt = a | b;
      OP_NOR:  simp_nxt = ~(a | b);
      OP_XOR:  simp_nxt = a ^ b;
      OP_XNOR: simp_nxt = ~(a ^ b);
      OP_NEG:  simp_nxt = word_t'(0) - a;
      OP_NOT:  simp_nxt = ~a;
      default: simp_nxt = a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      simp_r <= simp_nxt;
      pll_r  <= a[31:0] * b[31:0];
      plh_r  <= a[31:0] * b[63:32];
      phl_r  <= a[63:32] * b[31:0];
      mode_r <= in_mode;
      negq_r <= a[63] ^ b[63];
      dz_r   <= dz_nxt;
      a1_r   <= a;
    end
  end

  // divider on magnitudes, launched from the input
  word_t quo;
  sia_div_pipe #(.Steps(Steps)) u_div (
    .clk (clk), .en (adv), .num (mag_a), .den (dz_nxt ? word_t'(1) : mag_b),
    .quo (quo)
  );

  // stage 2: finish product; then carry side data alongside divider
  word_t side_r [2:Depth];
  logic [4:0] m_r [2:Depth];
  logic ng_r [2:Depth];
  logic z_r [2:Depth];
  word_t s2_nxt;
  always_comb begin
    s2_nxt = simp_r;
    if (mode_r == OP_MUL) begin
      s2_nxt = pll_r + {plh_r + phl_r, 32'd0};
    end else if (mode_r == OP_DIV && dz_r) begin
      s2_nxt = a1_r;
    end
  end
  for (genvar s = 2; s <= Depth; s++) begin : g_side
    if (s == 2) begin : g_tap
      always_ff @(posedge clk) begin
        if (adv) begin
          side_r[s] <= s2_nxt;
          m_r[s]    <= mode_r;
          ng_r[s]   <= negq_r;
          z_r[s]    <= dz_r;
        end
      end
    end else begin : g_tap
      always_ff @(posedge clk) begin
        if (adv) begin
          side_r[s] <= side_r[s-1];
          m_r[s]    <= m_r[s-1];
          ng_r[s]   <= ng_r[s-1];
          z_r[s]    <= z_r[s-1];
        end
      end
    end
  end

  // final stage: quotient sign fixed in the last register
  word_t q_al_r, res_sel;
  logic err_sel;
  always_ff @(posedge clk) begin
    if (adv) begin
      q_al_r <= ng_r[Steps] ? (word_t'(0) - quo) : quo;
    end
  end
  always_comb begin
    res_sel = side_r[Depth];
    if (m_r[Depth] == OP_DIV && !z_r[Depth]) res_sel = q_al_r;
  end
  assign err_sel = (m_r[Depth] == OP_DIV) && z_r[Depth];

  assign out_valid        = v_r[Depth-1];
  assign out_result       = res_sel;
  assign out_divide_error = err_sel;

  `SIA_ASSERT_IMP(a_err_div, clk, rst_n, out_valid && out_divide_error, m_r[Depth] == OP_DIV)
  `SIA_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `SIA_ASSERT_IMP(a_ready, clk, rst_n, !out_valid, in_ready)
endmodule
`default_nettype wire

FILE: sv/sia_div_pipe.sv
// Pipelined restoring divider on magnitudes, DataWidth / Steps quotient bits per stage.
`default_nettype none
module sia_div_pipe import sia_pkg::*; #(
  parameter int Steps = DivSteps
) (
  input  wire logic  clk,
  input  wire logic  en,
  input  word_t      num,
  input  word_t      den,
  output word_t      quo
);
  localparam int Bits = DataWidth / Steps;

  word_t rem_r [1:Steps-1];
  word_t q_r   [1:Steps];
  word_t d_r   [1:Steps-1];

  // each stage retires Bits quotient bits
  for (genvar s = 0; s < Steps; s++) begin : g_stage
    word_t rem_in;
    word_t q_in;
    word_t d_in;
    logic [DataWidth:0] rem_v;
    word_t q_v;

    // stage zero takes the inputs, later stages the previous registers
    if (s == 0) begin : g_src
      assign rem_in = '0;
      assign q_in   = num;
      assign d_in   = den;
    end else begin : g_src
      assign rem_in = rem_r[s];
      assign q_in   = q_r[s];
      assign d_in   = d_r[s];
    end

    always_comb begin
      rem_v = {1'b0, rem_in};
      q_v   = q_in;
      for (int i = 0; i < Bits; i++) begin
        rem_v = {rem_v[DataWidth-1:0], q_v[DataWidth-1]};
        q_v   = {q_v[DataWidth-2:0], 1'b0};
        if (rem_v >= {1'b0, d_in}) begin
          rem_v  = rem_v - {1'b0, d_in};
          q_v[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[s+1] <= q_v;
      end
    end

    // remainder and divisor only travel to stages that still need them
    if (s < Steps-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s+1] <= rem_v[DataWidth-1:0];
          d_r[s+1]   <= d_in;
        end
      end
    end
  end

  assign quo = q_r[Steps];
endmodule
`default_nettype wire

FILE: tb/tb_signed_integer_alu_top.sv
// Testbench for the signed integer ALU: directed table, then random words.
`timescale 1ns / 100ps
`default_nettype none
module tb_signed_integer_alu_top import sia_pkg::*; ();

  localparam int          NumRandom  = 1700;
  localparam int          CycleLimit = 400000;
  localparam logic [63:0] MinVal     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxVal     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] AllOnes    = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [63:0] result;
    logic        div_err;
  } alu_out_t;

  // One directed row; has_exp marks a typed-in expectation
  typedef struct {
    logic [63:0] a;
    logic [63:0] b;
    logic [4:0]  mode;
    logic        has_exp;
    alu_out_t    exp;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [63:0] in_operand_a;
  logic signed [63:0] in_operand_b;
  logic [4:0]         in_mode;
  logic               out_valid;
  logic               out_ready;
  logic signed [63:0] out_result;
  logic               out_divide_error;

  alu_out_t    pending_results[$];
  int          mismatches;
  int          cycles;
  bit          hold_off;
  bit          stim_done;
  dir_row_t    dir_rows[$];

  signed_integer_alu_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operand_a     (in_operand_a),
    .in_operand_b     (in_operand_b),
    .in_mode          (in_mode),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result       (out_result),
    .out_divide_error (out_divide_error)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Predicts the ALU output for one word
  function automatic alu_out_t alu_predict(logic [63:0] a, logic [63:0] b, logic [4:0] mode);
    alu_out_t    r;
    logic [63:0] mag_a;
    logic [63:0] mag_b;
    logic [63:0] quo;
    logic        lt_ab;
    logic        lt_ba;
    lt_ab = $signed(a) < $signed(b);
    lt_ba = $signed(b) < $signed(a);
    r.result  = a;
    r.div_err = 1'b0;
    case (mode)
      OP_MUL: r.result = a * b;
      OP_DIV: begin
        if (b == 64'd0) begin
          r.div_err = 1'b1;
        end else begin
          mag_a = a[63] ? -a : a;
          mag_b = b[63] ? -b : b;
          quo = mag_a / mag_b;
          r.result = (a[63] != b[63]) ? -quo : quo;
        end
      end
      OP_ADD:  r.result = a + b;
      OP_SUB:  r.result = a - b;
      OP_SHL:  r.result = (b >= 64) ? 64'd0 : a << b[5:0];
      OP_SHR:  r.result = $signed(a) >>> ((b >= 64) ? 6'd63 : b[5:0]);
      OP_EQ:   r.result = (a == b) ? AllOnes : 64'd0;
      OP_NE:   r.result = (a != b) ? AllOnes : 64'd0;
      OP_LT:   r.result = lt_ab ? AllOnes : 64'd0;
      OP_GT:   r.result = lt_ba ? AllOnes : 64'd0;
      OP_LE:   r.result = !lt_ba ? AllOnes : 64'd0;
      OP_GE:   r.result = !lt_ab ? AllOnes : 64'd0;
      OP_AND:  r.result = a & b;
      OP_NAND: r.result = ~(a & b);
      OP_OR:   r.result = a | b;
      OP_NOR:  r.result = ~(a | b);
      OP_XOR:  r.result = a ^ b;
      OP_XNOR: r.result = ~(a ^ b);
      OP_NEG:  r.result = -a;
      OP_NOT:  r.result = ~a;
      default: r.result = a;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand_word();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = MinVal;
      1: v = MaxVal;
      2: v = AllOnes;
      3: v = 64'd0;
      4: v = 64'($urandom_range(0, 80));
      5: v = -64'($urandom_range(1, 80));
      default: ;
    endcase
    return v;
  endfunction

  function automatic void add_row(logic [63:0] a, logic [63:0] b, logic [4:0] mode,
                                  logic has_exp, logic [63:0] res, logic err);
    dir_row_t row;
    row.a = a;
    row.b = b;
    row.mode = mode;
    row.has_exp = has_exp;
    row.exp = '{result: res, div_err: err};
    dir_rows.push_back(row);
  endfunction

  // Sends one word, holding valid until taken; valid stays up afterwards
  task automatic send_word(logic [63:0] a, logic [63:0] b, logic [4:0] mode,
                           alu_out_t exp);
    in_valid     <= 1'b1;
    in_operand_a <= a;
    in_operand_b <= b;
    in_mode      <= mode;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(exp);
  endtask

  // Stimulus
  initial begin
    logic [63:0] a;
    logic [63:0] b;
    logic [4:0]  mode;
    int          burst;
    int          sent;
    alu_out_t    exp;
    in_valid     = 1'b0;
    in_operand_a = '0;
    in_operand_b = '0;
    in_mode      = '0;
    rst_n        = 1'b0;
    stim_done    = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(MaxVal, 64'd1, OP_ADD, 1'b1, MinVal, 1'b0);
    add_row(MinVal, 64'd1, OP_SUB, 1'b1, MaxVal, 1'b0);
    add_row(64'd7, 64'd0, OP_DIV, 1'b1, 64'd7, 1'b1);
    add_row(MinVal, AllOnes, OP_DIV, 1'b1, MinVal, 1'b0);
    add_row(-64'sd7, 64'd2, OP_DIV, 1'b1, -64'sd3, 1'b0);
    add_row(64'd1, 64'd64, OP_SHL, 1'b1, 64'd0, 1'b0);
    add_row(64'd1, AllOnes, OP_SHL, 1'b1, 64'd0, 1'b0);
    add_row(MinVal, 64'd200, OP_SHR, 1'b1, AllOnes, 1'b0);
    add_row(MaxVal, AllOnes, OP_SHR, 1'b1, 64'd0, 1'b0);
    add_row(MinVal, 64'd0, OP_NEG, 1'b1, MinVal, 1'b0);
    add_row(64'd5, 64'd9, 5'd20, 1'b1, 64'd5, 1'b0);
    add_row(MinVal, 64'd9, 5'd31, 1'b1, MinVal, 1'b0);
    add_row(MaxVal, MaxVal, OP_MUL, 1'b0, 64'd0, 1'b0);
    add_row(MinVal, MaxVal, OP_LT, 1'b1, AllOnes, 1'b0);
    for (int m = OP_EQ; m <= OP_NOT; m++) add_row(MinVal, 64'h1234, m[4:0], 1'b0, 64'd0, 1'b0);

    foreach (dir_rows[i]) begin
      exp = dir_rows[i].has_exp ? dir_rows[i].exp
                                : alu_predict(dir_rows[i].a, dir_rows[i].b, dir_rows[i].mode);
      send_word(dir_rows[i].a, dir_rows[i].b, dir_rows[i].mode, exp);
    end
    in_valid <= 1'b0;
    @(posedge clk);

    // Random bursts with gaps; one pause drains everything mid-run
    sent = 0;
    while (sent < NumRandom) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && sent < NumRandom; k++) begin
        a = rand_word();
        b = rand_word();
        mode = 5'(($urandom_range(0, 7) == 0) ? $urandom_range(20, 31)
                                              : $urandom_range(0, 19));
        sent++;
        send_word(a, b, mode, alu_predict(a, b, mode));
      end
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (sent >= NumRandom / 2 && sent - burst < NumRandom / 2) begin
        while (pending_results.size() != 0) @(posedge clk);
      end
    end
    stim_done = 1'b1;
  end

  // Long receiver hold-off once, early in the random part
  initial begin
    hold_off = 1'b0;
    wait (rst_n);
    repeat (150) @(posedge clk);
    hold_off <= 1'b1;
    repeat (60) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_off && ((cycles % 500 < 200) || ($urandom_range(0, 3) != 0));
    end
  end

  // Result checking
  always @(posedge clk) begin
    alu_out_t exp;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_result);
      end else begin
        exp = pending_results.pop_front();
        if (out_result !== exp.result || out_divide_error !== exp.div_err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected result %h err %b, got %h err %b",
                     exp.result, exp.div_err, out_result, out_divide_error);
        end
      end
    end
  end

  // Cycle limit
  initial begin
    mismatches = 0;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("** signed_integer_alu_top: FAILED **");
        $finish;
      end
    end
  end

  // End of run
  initial begin
    wait (stim_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("** signed_integer_alu_top: PASSED **");
    end else begin
      $display("** signed_integer_alu_top: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire
